// ===== design/kfd_pkg.sv =====
// ----------------------------------------------------------------------------
// KISS frame decoder package
// Byte codes, result kinds, sizes and the result record shared by the parser
// and the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kfd_pkg;

  localparam int unsigned MaxFrameBytes = 1024;
  localparam int unsigned CountW        = $clog2(MaxFrameBytes + 1);
  localparam int unsigned LenW          = 10;

  localparam logic [7:0] FendCode  = 8'hC0;
  localparam logic [7:0] FescCode  = 8'hDB;
  localparam logic [7:0] TfendCode = 8'hDC;
  localparam logic [7:0] TfescCode = 8'hDD;

  localparam logic [3:0] CmdData       = 4'h0;
  localparam logic [3:0] CmdTxDelay    = 4'h1;
  localparam logic [3:0] CmdTxTail     = 4'h4;
  localparam logic [3:0] CmdFullDuplex = 4'h5;

  localparam logic [1:0] SetTxDelay    = 2'd0;
  localparam logic [1:0] SetTxTail     = 2'd1;
  localparam logic [1:0] SetFullDuplex = 2'd2;

  typedef enum logic [1:0] {
    KindData    = 2'd0,
    KindEnd     = 2'd1,
    KindSetting = 2'd2
  } kind_e;

  typedef struct packed {
    logic            emit;
    kind_e           kind;
    logic [7:0]      byte_value;
    logic [1:0]      setting_id;
    logic [LenW-1:0] frame_length;
    logic            truncated;
  } kfd_result_t;

endpackage

`default_nettype wire

// ===== design/kfd_parser.sv =====
// ----------------------------------------------------------------------------
// KISS frame parser
// Frame state and unescaping; consumes one byte whenever step_i is high and
// reports the result that byte causes, if any.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kfd_parser (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire logic [7:0]          byte_i,
  output kfd_pkg::kfd_result_t     result_o
);
  import kfd_pkg::*;

  logic [CountW-1:0] cnt_q, cnt_d;
  logic              esc_q, esc_d;
  logic [3:0]        cmd_q, cmd_d;
  logic [7:0]        first_q, first_d;
  logic              ovf_q, ovf_d;

  logic              keep;
  logic [7:0]        keep_val;
  logic [CountW-1:0] cnt_m1;
  kfd_result_t       res;

  assign cnt_m1 = cnt_q - CountW'(1);

  always_comb begin
    cnt_d    = cnt_q;
    esc_d    = esc_q;
    cmd_d    = cmd_q;
    first_d  = first_q;
    ovf_d    = ovf_q;
    keep     = 1'b0;
    keep_val = byte_i;
    res      = '0;

    if (esc_q) begin
      // A bad escape drops the byte; the escape lasts for one byte only.
      esc_d = 1'b0;
      if (byte_i == TfendCode) begin
        keep     = 1'b1;
        keep_val = FendCode;
      end else if (byte_i == TfescCode) begin
        keep     = 1'b1;
        keep_val = FescCode;
      end
    end else if (byte_i == FendCode) begin
      if (cnt_q != '0) begin
        if (cmd_q == CmdData) begin
          res.emit         = 1'b1;
          res.kind         = KindEnd;
          res.frame_length = LenW'(cnt_m1);
          res.truncated    = ovf_q;
        end else if (cnt_q >= CountW'(2)) begin
          res.kind       = KindSetting;
          res.byte_value = first_q;
          unique case (cmd_q)
            CmdTxDelay: begin
              res.emit       = 1'b1;
              res.setting_id = SetTxDelay;
            end
            CmdTxTail: begin
              res.emit       = 1'b1;
              res.setting_id = SetTxTail;
            end
            CmdFullDuplex: begin
              res.emit       = 1'b1;
              res.setting_id = SetFullDuplex;
            end
            default: res.emit = 1'b0;
          endcase
        end
      end
      cnt_d = '0;
      ovf_d = 1'b0;
    end else if (cnt_q == '0) begin
      // The command byte is never unescaped.
      cmd_d   = byte_i[3:0];
      first_d = '0;
      ovf_d   = 1'b0;
      cnt_d   = CountW'(1);
    end else if (byte_i == FescCode) begin
      esc_d = 1'b1;
    end else begin
      keep = 1'b1;
    end

    if (keep) begin
      if (cnt_q >= CountW'(MaxFrameBytes)) begin
        ovf_d = 1'b1;
      end else begin
        if (cnt_q == CountW'(1)) begin
          first_d = keep_val;
        end
        cnt_d = cnt_q + CountW'(1);
        if (cmd_q == CmdData) begin
          res.emit       = 1'b1;
          res.kind       = KindData;
          res.byte_value = keep_val;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      esc_q   <= 1'b0;
      cmd_q   <= '0;
      first_q <= '0;
      ovf_q   <= 1'b0;
    end else if (step_i) begin
      cnt_q   <= cnt_d;
      esc_q   <= esc_d;
      cmd_q   <= cmd_d;
      first_q <= first_d;
      ovf_q   <= ovf_d;
    end
  end

  assign result_o = res;

endmodule

`default_nettype wire

// ===== design/kiss_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// KISS frame decoder
// Receive deframer for a KISS byte stream: data bytes, frame end markers and
// TNC setting updates.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_ready_o / rx_byte_i) takes one raw link
//   byte per transaction. The output channel (out_valid_o / out_ready_i and
//   the result fields) gives at most one result per input byte: an unescaped
//   data byte, an end-of-frame marker with length and truncation flag, or a
//   setting update (TX delay, TX tail, full duplex).
//   Each byte sits in an input register, is decoded combinationally, and its
//   result lands in the output register. One byte is taken every cycle while
//   the receiver keeps out_ready_i high.
//   If the receiver stalls, the output register holds its result; the input
//   register still fills, and only then does in_ready_o drop.
//   Reset clears both valid flags and the frame state: no frame is open and
//   the first byte after reset is taken as a command byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kiss_frame_decoder (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [7:0]               rx_byte_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [1:0]                    kind_o,
  output logic [7:0]                    byte_value_o,
  output logic [1:0]                    setting_id_o,
  output logic [kfd_pkg::LenW-1:0]      frame_length_o,
  output logic                          truncated_o
);
  import kfd_pkg::*;

  logic        in_vld_q;
  logic [7:0]  in_byte_q;
  logic        out_vld_q;
  kfd_result_t out_q;
  kfd_result_t res;
  logic        out_free;
  logic        step;

  assign out_free   = !out_vld_q || out_ready_i;
  assign step       = in_vld_q && out_free;
  assign in_ready_o = !in_vld_q || step;

  kfd_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (in_byte_q),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= step && res.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res.emit && out_free) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign kind_o         = out_q.kind;
  assign byte_value_o   = out_q.byte_value;
  assign setting_id_o   = out_q.setting_id;
  assign frame_length_o = out_q.frame_length;
  assign truncated_o    = out_q.truncated;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// KISS frame decoder testbench
// Drives raw link bytes into the decoder, predicts the data bytes, end
// markers and setting updates from a model of the frame state, and compares
// each result transaction field by field. Both channels idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import kfd_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandomItems = 800;

  typedef struct packed {
    kind_e           kind;
    logic [7:0]      byte_value;
    logic [1:0]      setting_id;
    logic [LenW-1:0] frame_length;
    logic            truncated;
  } decoded_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [7:0]       rx_byte_i = 8'h00;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [1:0]       kind_o;
  logic [7:0]       byte_value_o;
  logic [1:0]       setting_id_o;
  logic [LenW-1:0]  frame_length_o;
  logic             truncated_o;

  // Predicted decoder state.
  logic [CountW-1:0] frame_bytes = '0;
  logic              escape_seen = 1'b0;
  logic [3:0]        command_low = 4'h0;
  logic [7:0]        setting_value = 8'h00;
  logic              bytes_dropped = 1'b0;

  decoded_t    decoded_q[$];
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  bit          steady = 1'b0;

  kiss_frame_decoder uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .byte_value_o   (byte_value_o),
    .setting_id_o   (setting_id_o),
    .frame_length_o (frame_length_o),
    .truncated_o    (truncated_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= 26);
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic void push_result(kind_e k, logic [7:0] v, logic [1:0] id,
                                      logic [LenW-1:0] n, logic t);
    decoded_t r;
    r.kind = k;
    r.byte_value = v;
    r.setting_id = id;
    r.frame_length = n;
    r.truncated = t;
    decoded_q.push_back(r);
  endfunction

  function automatic void keep_frame_byte(logic [7:0] v);
    if (frame_bytes >= MaxFrameBytes) begin
      bytes_dropped = 1'b1;
    end else begin
      if (frame_bytes == 1) setting_value = v;
      frame_bytes = frame_bytes + 1'b1;
      if (command_low == CmdData) push_result(KindData, v, '0, '0, 1'b0);
    end
  endfunction

  function automatic void close_frame();
    logic [CountW-1:0] data_bytes;
    if (frame_bytes != 0) begin
      data_bytes = frame_bytes - 1'b1;
      if (command_low == CmdData) begin
        push_result(KindEnd, 8'h00, '0, data_bytes[LenW-1:0], bytes_dropped);
      end else if (frame_bytes >= 2) begin
        case (command_low)
          CmdTxDelay:    push_result(KindSetting, setting_value, SetTxDelay, '0, 1'b0);
          CmdTxTail:     push_result(KindSetting, setting_value, SetTxTail, '0, 1'b0);
          CmdFullDuplex: push_result(KindSetting, setting_value, SetFullDuplex, '0, 1'b0);
          default: ;
        endcase
      end
    end
    frame_bytes = '0;
    bytes_dropped = 1'b0;
  endfunction

  function automatic void decode_rx_byte(logic [7:0] b);
    if (escape_seen) begin
      // An escape covers exactly one byte; anything but TFEND/TFESC is lost.
      escape_seen = 1'b0;
      if (b == TfendCode) keep_frame_byte(FendCode);
      else if (b == TfescCode) keep_frame_byte(FescCode);
    end else if (b == FendCode) begin
      close_frame();
    end else if (frame_bytes == 0) begin
      command_low = b[3:0];
      setting_value = 8'h00;
      bytes_dropped = 1'b0;
      frame_bytes = CountW'(1);
    end else if (b == FescCode) begin
      escape_seen = 1'b1;
    end else begin
      keep_frame_byte(b);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic compare_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    decoded_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d value %0h",
                 $time, kind_o, byte_value_o);
        errors++;
      end else begin
        exp_r = decoded_q.pop_front();
        compare_field("kind", exp_r.kind, kind_o);
        compare_field("byte_value", exp_r.byte_value, byte_value_o);
        compare_field("setting_id", exp_r.setting_id, setting_id_o);
        compare_field("frame_length", exp_r.frame_length, frame_length_o);
        compare_field("truncated", exp_r.truncated, truncated_o);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic send_byte(logic [7:0] b);
    if (!steady && $urandom_range(99) < 26) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 26);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    decode_rx_byte(b);
    items_sent++;
  endtask

  // Sends a payload byte with the escaping a well-behaved sender would use.
  task automatic send_escaped(logic [7:0] v);
    if (v == FendCode) begin
      send_byte(FescCode);
      send_byte(TfendCode);
    end else if (v == FescCode) begin
      send_byte(FescCode);
      send_byte(TfescCode);
    end else begin
      send_byte(v);
    end
  endtask

  function automatic logic [7:0] random_payload();
    logic [7:0] specials[4];
    specials = '{FendCode, FescCode, TfendCode, TfescCode};
    if ($urandom_range(7) == 0) return specials[$urandom_range(3)];
    return 8'($urandom_range(255));
  endfunction

  task automatic send_long_frame(logic [7:0] command, int unsigned n);
    send_byte(FendCode);
    send_byte(command);
    repeat (n) send_escaped(random_payload());
    send_byte(FendCode);
  endtask

  // Waits with the input idle until every predicted result has come out.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_data_frames();
    // The very first bytes after reset arrive with no opening FEND.
    send_byte(8'h00);
    send_byte(8'h41);
    send_byte(FendCode);
    send_byte(FendCode);
    send_byte(8'hF0);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(FescCode);
    send_byte(TfendCode);
    send_byte(FescCode);
    send_byte(TfescCode);
    send_byte(TfendCode);
    send_byte(FendCode);
    // An empty data frame still reports length zero.
    send_byte(8'h00);
    send_byte(FendCode);
  endtask

  task automatic test_repeated_fend();
    repeat (3) send_byte(FendCode);
  endtask

  task automatic test_bad_escape();
    send_byte(8'h00);
    send_byte(8'h11);
    send_byte(FescCode);
    send_byte(8'h42);
    send_byte(FescCode);
    send_byte(FendCode);
    send_byte(8'h43);
    send_byte(FescCode);
    send_byte(FescCode);
    send_byte(TfendCode);
    send_byte(FendCode);
    // The command byte is never unescaped, so FESC here is command 0xB.
    send_byte(FescCode);
    send_byte(8'h05);
    send_byte(FendCode);
  endtask

  task automatic test_settings();
    send_byte(8'h01);
    send_byte(8'h00);
    send_byte(8'h99);
    send_byte(FendCode);
    send_byte(8'h14);
    send_byte(8'hFF);
    send_byte(FendCode);
    send_byte(8'hE5);
    send_byte(FescCode);
    send_byte(TfendCode);
    send_byte(FendCode);
    // A control frame with no value byte gives nothing.
    send_byte(8'h01);
    send_byte(FendCode);
    send_byte(8'h02);
    send_byte(8'h33);
    send_byte(FendCode);
    send_byte(8'h0F);
    send_byte(8'h7E);
    send_byte(FendCode);
  endtask

  // One data byte more than the frame can hold: the last byte that fits is
  // kept and the one after it is dropped.
  task automatic test_long_frames();
    send_long_frame(8'h00, MaxFrameBytes);
  endtask

  task automatic send_random_frame();
    int unsigned pick;
    int unsigned n;
    logic [7:0]  command;
    logic [7:0]  v;
    pick = $urandom_range(99);
    if (pick < 60) command = {4'($urandom_range(15)), CmdData};
    else if (pick < 68) command = {4'($urandom_range(15)), CmdTxDelay};
    else if (pick < 76) command = {4'($urandom_range(15)), CmdTxTail};
    else if (pick < 84) command = {4'($urandom_range(15)), CmdFullDuplex};
    else command = 8'($urandom_range(255));
    if ($urandom_range(99) < 30) send_byte(FendCode);
    send_byte(command);
    n = ($urandom_range(19) == 0) ? $urandom_range(60) : $urandom_range(8);
    repeat (n) begin
      v = random_payload();
      // A few raw bytes give broken escapes and stray frame ends.
      if ($urandom_range(19) == 0) send_byte(v);
      else send_escaped(v);
    end
    if ($urandom_range(99) < 95) send_byte(FendCode);
  endtask

  task automatic test_random_stream();
    int unsigned stop_at;
    stop_at = items_sent + RandomItems;
    steady = 1'b1;
    while (items_sent < stop_at) begin
      if (items_sent > stop_at - RandomItems + 300) steady = 1'b0;
      if ($urandom_range(99) < 8) send_byte(8'($urandom_range(255)));
      else send_random_frame();
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_data_frames();
    test_repeated_fend();
    test_bad_escape();
    test_settings();
    drain_results();
    test_long_frames();
    test_random_stream();
    in_valid_i <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
